// ----- src/dfmt_pkg.sv -----
// Shared types and constants for the decimal field formatter.
`timescale 1ns / 1ps

package dfmt_pkg;

  // Widest field the block is built for by default.
  localparam int MAX_DIGITS = 10;

  localparam int ValueW = 32;
  localparam int AddrW  = 6;
  localparam int CharW  = 6;

  // ASCII codes, cut to the six-bit character field.
  localparam logic [CharW-1:0] CHR_ZERO  = 6'h30;
  localparam logic [CharW-1:0] CHR_SPACE = 6'h20;

  // Fixed-point reciprocal of ten: floor(q / 10) == (q * RECIP_10) >> RECIP_SHIFT
  // for every 32-bit q.
  localparam logic [ValueW-1:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int                RECIP_SHIFT = 35;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  // Result of one pass through the divide-by-ten unit.
  typedef struct packed {
    logic [ValueW-1:0] quot;
    logic [3:0]        digit;
  } div10_t;

endpackage

// ----- src/dfmt_div10.sv -----
// Shared divide-by-ten unit: quotient by reciprocal multiply, digit by subtraction.
`timescale 1ns / 1ps

module dfmt_div10 (
  input  logic [dfmt_pkg::ValueW-1:0] dividend_i,
  output dfmt_pkg::div10_t            res_o
);

  localparam int ValueW = dfmt_pkg::ValueW;

  logic [2*ValueW-1:0] prod;
  logic [ValueW-1:0]   quot;
  logic [ValueW-1:0]   times_ten;
  logic [ValueW-1:0]   rem;

  assign prod      = dividend_i * dfmt_pkg::RECIP_10;
  assign quot      = ValueW'(prod[2*ValueW-1:dfmt_pkg::RECIP_SHIFT]);
  // quot * 10 as two shifts and an add
  assign times_ten = (quot << 3) + (quot << 1);
  assign rem       = dividend_i - times_ten;

  assign res_o.quot  = quot;
  assign res_o.digit = rem[3:0];

endmodule

// ----- src/decimal_field_formatter.sv -----
// Top level of the decimal field formatter: sequencer, digit register and output stage.
`timescale 1ns / 1ps

// Usage
// - Input channel (in_valid_i / in_stall_o): one beat carries a padding mode,
//   the field's leftmost cell, the field width and a 32-bit unsigned value.
//   A beat is taken at a rising edge with in_valid_i high and in_stall_o low.
// - Output channel (out_valid_o / out_stall_i): one beat per field cell,
//   rightmost (units) cell first, each with its cell address and an ASCII
//   digit or space; last_o marks the leftmost cell of the field.
// - Width: 0 counts as 1, widths above MaxDigits saturate to MaxDigits.
//   Addresses are not clamped to the display size.
// - Flow: the block works on one item at a time. After the input beat it
//   produces one character per cycle, while the receiver does not stall,
//   from a single divide-by-ten unit, and holds the input stalled until the
//   last character of the item is registered. The first character goes
//   through the item registers and then the output register.
// - The output register frees the sequencer from the receiver: a next item
//   is accepted while the final character of the previous one still waits.
// - When the receiver stalls, the output beat holds and the sequencer waits.
// - Reset empties the output register and returns the sequencer to idle.
module decimal_field_formatter #(
  parameter int MaxDigits = dfmt_pkg::MAX_DIGITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       op_i,
  input  logic [4:0] position_i,
  input  logic [3:0] digit_count_i,
  input  logic [31:0] value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [5:0] address_o,
  output logic [5:0] character_o,
  output logic       last_o
);

  localparam int ValueW = dfmt_pkg::ValueW;
  localparam int AddrW  = dfmt_pkg::AddrW;
  localparam int CharW  = dfmt_pkg::CharW;
  // Cells left to emit after the current one: 0 .. MaxDigits-1.
  localparam int CntW   = (MaxDigits > 1) ? $clog2(MaxDigits) : 1;
  localparam logic [4:0] MaxN = 5'(MaxDigits);

  dfmt_pkg::state_e state_q, state_d;

  // Item registers
  logic [ValueW-1:0] q_q, q_d;
  logic              mode_q, mode_d;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic [CntW-1:0]   rem_q, rem_d;
  logic              first_q, first_d;

  // Output stage
  logic              out_valid_q, out_valid_d;
  logic [AddrW-1:0]  out_addr_q;
  logic [CharW-1:0]  out_char_q;
  logic              out_last_q;

  logic              in_take;
  logic              out_free;
  logic              emit;
  logic              is_last;
  logic [4:0]        n_sat;
  logic [CharW-1:0]  char_next;
  dfmt_pkg::div10_t  div;

  dfmt_div10 u_div10 (
    .dividend_i (q_q),
    .res_o      (div)
  );

  // Field width after the zero and saturation rules.
  always_comb begin
    if (digit_count_i == 4'd0) begin
      n_sat = 5'd1;
    end else if ({1'b0, digit_count_i} > MaxN) begin
      n_sat = MaxN;
    end else begin
      n_sat = {1'b0, digit_count_i};
    end
  end

  // Units cell always shows a digit; above it a digit only while the
  // running quotient is nonzero, padding otherwise.
  always_comb begin
    if (first_q || (q_q != '0)) begin
      char_next = CharW'(dfmt_pkg::CHR_ZERO + {2'b00, div.digit});
    end else if (mode_q) begin
      char_next = dfmt_pkg::CHR_ZERO;
    end else begin
      char_next = dfmt_pkg::CHR_SPACE;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign is_last  = (rem_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dfmt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Sequencer: next state and datapath steering.
  always_comb begin
    state_d     = state_q;
    in_take     = 1'b0;
    emit        = 1'b0;
    q_d         = q_q;
    mode_d      = mode_q;
    addr_d      = addr_q;
    rem_d       = rem_q;
    first_d     = first_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      dfmt_pkg::ST_IDLE: begin
        in_take = in_valid_i;
        if (in_valid_i) begin
          q_d     = value_i;
          mode_d  = op_i;
          addr_d  = AddrW'({1'b0, position_i}) + AddrW'(n_sat) - AddrW'(1);
          rem_d   = CntW'(n_sat - 5'd1);
          first_d = 1'b1;
          state_d = dfmt_pkg::ST_RUN;
        end
      end
      dfmt_pkg::ST_RUN: begin
        if (out_free) begin
          // Advance one cell to the left.
          emit        = 1'b1;
          out_valid_d = 1'b1;
          q_d         = div.quot;
          addr_d      = addr_q - AddrW'(1);
          rem_d       = rem_q - CntW'(1);
          first_d     = 1'b0;
          if (is_last) begin
            state_d = dfmt_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = dfmt_pkg::ST_IDLE;
      end
    endcase
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_take || emit) begin
      q_q     <= q_d;
      mode_q  <= mode_d;
      addr_q  <= addr_d;
      rem_q   <= rem_d;
      first_q <= first_d;
    end
    if (emit) begin
      out_addr_q <= addr_q;
      out_char_q <= char_next;
      out_last_q <= is_last;
    end
  end

  assign in_stall_o  = (state_q != dfmt_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign address_o   = out_addr_q;
  assign character_o = out_char_q;
  assign last_o      = out_last_q;

endmodule

// ----- src/dfmt_checker.sv -----
// Port-level checks for the decimal field formatter and their bind.
`timescale 1ns / 1ps

module dfmt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [5:0] address_o,
  input logic [5:0] character_o,
  input logic       last_o
);

  // A taken input beat starts conversion: no second item right after it.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after item taken");

  // A stalled output beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(address_o) && $stable(character_o) && $stable(last_o)))
    else $error("stalled output beat changed");

  // Every character is a decimal digit or a space.
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((character_o == 6'h20) || ((character_o >= 6'h30) && (character_o <= 6'h39))))
    else $error("character outside digit and space codes");

endmodule

bind decimal_field_formatter dfmt_checker u_dfmt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .address_o   (address_o),
  .character_o (character_o),
  .last_o      (last_o)
);

// ----- tb/decimal_field_formatter_tb.sv -----
// Self-checking testbench for the decimal field formatter.
`timescale 1ns / 1ps

module decimal_field_formatter_tb;

  // Padding modes carried on op_i.
  localparam logic PAD_SPACE = 1'b0;
  localparam logic PAD_ZERO  = 1'b1;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int LONG_HOLD    = 80;   // receiver hold-off for the pressure phase
  localparam int RANDOM_BEATS = 150;
  localparam int REPORT_MAX   = 10;

  // One character beat as seen on the output channel.
  typedef struct packed {
    logic [dfmt_pkg::AddrW-1:0] address;
    logic [dfmt_pkg::CharW-1:0] character;
    logic                       last;
  } cell_t;

  // Keeps the characters each accepted field must produce, oldest first,
  // and checks every output beat against the head of that queue.
  class field_scoreboard;
    cell_t pending_cells[$];
    int    fields_noted;
    int    cells_checked;
    int    errors;

    function int pending();
      return pending_cells.size();
    endfunction

    // Expand one accepted field into its characters, units cell first.
    function void note_field(logic pad, logic [4:0] pos, logic [3:0] cnt,
                             logic [31:0] val);
      int          width;
      int          k;
      logic [31:0] rest;
      cell_t       c;
      width = (cnt == 4'd0) ? 1 :
              ((int'(cnt) > dfmt_pkg::MAX_DIGITS) ? dfmt_pkg::MAX_DIGITS : int'(cnt));
      rest  = val;
      for (k = 0; k < width; k++) begin
        // The units cell always shows a digit; above it, padding once the
        // quotient has run out.
        if (k == 0 || rest != 32'd0) begin
          c.character = dfmt_pkg::CHR_ZERO + dfmt_pkg::CharW'(rest % 32'd10);
        end else begin
          c.character = (pad == PAD_ZERO) ? dfmt_pkg::CHR_ZERO : dfmt_pkg::CHR_SPACE;
        end
        rest      = rest / 32'd10;
        c.address = dfmt_pkg::AddrW'(int'(pos) + width - 1 - k);
        c.last    = (k == width - 1);
        pending_cells.push_back(c);
      end
      fields_noted++;
    endfunction

    function void check_cell(cell_t got);
      cell_t want;
      if (pending_cells.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("%0t: unexpected character beat addr=%0d char=%h last=%b",
                   $realtime, got.address, got.character, got.last);
        end
        return;
      end
      want = pending_cells.pop_front();
      cells_checked++;
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display({"%0t: character beat mismatch: expected addr=%0d char=%h last=%b,",
                    " got addr=%0d char=%h last=%b"},
                   $realtime, want.address, want.character, want.last,
                   got.address, got.character, got.last);
        end
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic        op_i          = PAD_SPACE;
  logic [4:0]  position_i    = '0;
  logic [3:0]  digit_count_i = 4'd1;
  logic [31:0] value_i       = '0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [5:0]  address_o;
  logic [5:0]  character_o;
  logic        last_o;

  field_scoreboard sb = new();

  // Shared between the sender and the receiver process; cycles feeds the watchdog.
  bit idle_on;        // random idling allowed on both sides
  bit hold_request;   // ask the receiver for one long hold-off
  int cycles;

  decimal_field_formatter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .position_i    (position_i),
    .digit_count_i (digit_count_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .address_o     (address_o),
    .character_o   (character_o),
    .last_o        (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hold reset asserted at the start, then release it for good.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Watchdog: a correct run ends far below this.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters still pending",
               cycles, sb.pending());
      $display("status: fail");
      $finish;
    end
  end

  // Sample both channels with the values that stood before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.note_field(op_i, position_i, digit_count_i, value_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_cell(cell_t'{address_o, character_o, last_o});
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request so the
  // output register and then the sequencer back up into the input.
  initial begin : receiver
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_request = 1'b0;
        out_stall_i  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic logic [31:0] ten_pow(int exp);
    logic [31:0] p;
    p = 32'd1;
    repeat (exp) p = p * 32'd10;
    return p;
  endfunction

  // Spread values over every magnitude, with extra weight on decade edges.
  function automatic logic [31:0] pick_value();
    int mag;
    mag = $urandom_range(1, 9);
    case ($urandom_range(0, 4))
      0:       return $urandom();
      1:       return $urandom_range(0, 9);
      2:       return $urandom_range(0, ten_pow(mag) - 1);
      3:       return ten_pow($urandom_range(0, 9));
      default: return ten_pow(mag) - 32'd1;
    endcase
  endfunction

  // Offer one field and hold it until the block takes it. Valid stays high
  // afterwards; sender_pause drops it when a gap is wanted.
  task automatic send_field(input logic pad, input logic [4:0] pos,
                            input logic [3:0] cnt, input logic [31:0] val);
    in_valid_i    <= 1'b1;
    op_i          <= pad;
    position_i    <= pos;
    digit_count_i <= cnt;
    value_i       <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Random sender gap; scramble the payload while valid is low.
  task automatic sender_pause();
    if (idle_on && $urandom_range(0, 2) == 0) begin
      in_valid_i    <= 1'b0;
      op_i          <= 1'($urandom());
      position_i    <= 5'($urandom());
      digit_count_i <= 4'($urandom());
      value_i       <= $urandom();
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic send_random_field();
    logic [3:0] cnt;
    // Mostly legal widths; now and then zero or an oversized width.
    cnt = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                      : 4'($urandom_range(1, dfmt_pkg::MAX_DIGITS));
    send_field(1'($urandom()), 5'($urandom()), cnt, pick_value());
  endtask

  initial begin : stimulus
    int i;
    idle_on      = 1'b1;
    hold_request = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // Directed fields: zero value, extremes of every field, zero and
    // oversized widths, truncated values, inner zeros next to padding.
    send_field(PAD_SPACE, 5'd0,  4'd1,  32'd0);           sender_pause();
    send_field(PAD_ZERO,  5'd0,  4'd10, 32'd0);           sender_pause();
    send_field(PAD_SPACE, 5'd0,  4'd10, 32'd0);           sender_pause();
    send_field(PAD_SPACE, 5'd31, 4'd10, 32'hFFFF_FFFF);   sender_pause();
    send_field(PAD_ZERO,  5'd31, 4'd10, 32'hFFFF_FFFF);   sender_pause();
    send_field(PAD_ZERO,  5'd31, 4'd1,  32'hFFFF_FFFF);   sender_pause();
    send_field(PAD_SPACE, 5'd5,  4'd0,  32'd7);           sender_pause();
    send_field(PAD_ZERO,  5'd5,  4'd0,  32'd12345);       sender_pause();
    send_field(PAD_SPACE, 5'd2,  4'd15, 32'd1234567890);  sender_pause();
    send_field(PAD_ZERO,  5'd20, 4'd11, 32'd42);          sender_pause();
    send_field(PAD_SPACE, 5'd10, 4'd3,  32'd12345);       sender_pause();
    send_field(PAD_ZERO,  5'd10, 4'd3,  32'd5);           sender_pause();
    send_field(PAD_SPACE, 5'd0,  4'd5,  32'd100);         sender_pause();
    send_field(PAD_ZERO,  5'd0,  4'd5,  32'd100);         sender_pause();
    send_field(PAD_SPACE, 5'd16, 4'd10, 32'd1000000000);  sender_pause();
    send_field(PAD_ZERO,  5'd16, 4'd10, 32'd999999999);   sender_pause();
    send_field(PAD_ZERO,  5'd7,  4'd4,  32'd9);           sender_pause();
    send_field(PAD_SPACE, 5'd30, 4'd2,  32'd10);          sender_pause();
    send_field(PAD_SPACE, 5'd21, 4'd8,  32'd1048576);     sender_pause();

    for (i = 0; i < RANDOM_BEATS; i++) begin
      // A quiet stretch in the middle, and none at all near the end.
      idle_on = !((i >= 50 && i < 70) || i >= 120);
      if (i == 90) begin
        hold_request = 1'b1;
      end
      send_random_field();
      // Keep offering back to back while the long hold-off runs.
      if (!(i >= 90 && i < 100)) begin
        sender_pause();
      end
    end
    in_valid_i <= 1'b0;

    // Drain, then leave room for any stray beat to show up.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4 * (dfmt_pkg::MAX_DIGITS + 2)) @(posedge clk_i);

    $display("covered %0d fields and %0d character beats: widths 0 to 15,",
             sb.fields_noted, sb.cells_checked);
    $display("both padding modes, random stalls on both channels and one %0d-cycle %s%0d errors",
             LONG_HOLD, "output hold-off; ", sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/dfmt_pkg.sv
src/dfmt_div10.sv
src/decimal_field_formatter.sv
src/dfmt_checker.sv
tb/decimal_field_formatter_tb.sv
